/* rtl/mts_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants for the memory test sequencer.
// No dependencies; compile first.
package mts_pkg;

    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 20;
    localparam int WORDS_W    = ADDR_W + 1;
    localparam int ITER_W     = 16;
    localparam int CFG_DATA_W = WORDS_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_WORDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT   = 1'b1;

    localparam logic [WORDS_W-1:0] REGION_WORDS_RST = WORDS_W'(32768);
    localparam logic [ITER_W-1:0]  ITER_LIMIT_RST   = ITER_W'(1);
    localparam logic [WORDS_W-1:0] MIN_WORDS        = WORDS_W'(2);
    localparam logic [WORDS_W-1:0] MAX_WORDS        = WORDS_W'(1) << ADDR_W;

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_READ  = 2'd2;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_DATA     = 4'd1;
    localparam logic [3:0] PH_AFILL    = 4'd2;
    localparam logic [3:0] PH_AHIGH0   = 4'd3;
    localparam logic [3:0] PH_AHIGHCHK = 4'd4;
    localparam logic [3:0] PH_AHIGHEND = 4'd5;
    localparam logic [3:0] PH_ALOW     = 4'd6;
    localparam logic [3:0] PH_IFILL    = 4'd7;
    localparam logic [3:0] PH_IINV     = 4'd8;
    localparam logic [3:0] PH_IZERO    = 4'd9;
    localparam logic [3:0] PH_DONE     = 4'd10;

    localparam logic [DATA_W-1:0] PAT_A = 32'hAAAA_AAAA;
    localparam logic [DATA_W-1:0] PAT_5 = 32'h5555_5555;

    localparam logic [DATA_W-1:0] SEEDS [8] = '{
        32'h0000_0001, 32'h0000_0003, 32'h0000_0007, 32'h0000_000F,
        32'h0000_0005, 32'h0000_0015, 32'h0000_0055, 32'hAAAA_AAAA
    };

    typedef struct packed {
        logic [3:0]        phase;
        logic [2:0]        sub_step;
        logic [2:0]        seed_index;
        logic [DATA_W-1:0] walk_value;
        logic [ADDR_W-1:0] scan_offset;
        logic [ADDR_W-1:0] probe_offset;
        logic [ITER_W-1:0] passes_done;
        logic [DATA_W-1:0] errors;
        logic [DATA_W-1:0] expected_value;
        logic              read_pending;
        logic              skip_compare;
    } mts_state_t;

    typedef struct packed {
        logic [1:0]        access_kind;
        logic              to_scratch;
        logic [ADDR_W-1:0] word_offset;
        logic [DATA_W-1:0] write_data;
        logic              mismatch;
        logic [DATA_W-1:0] error_count;
        logic              done_res;
        logic              failed;
    } mts_result_t;

endpackage

/* rtl/mts_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and access words.
// Depends on mts_pkg.
interface mts_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [mts_pkg::DATA_W-1:0] read_data;

    modport source (output valid, output cmd, output read_data, input ready);
    modport sink   (input valid, input cmd, input read_data, output ready);
endinterface

interface mts_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                access_kind;
    logic                      to_scratch;
    logic [mts_pkg::ADDR_W-1:0] word_offset;
    logic [mts_pkg::DATA_W-1:0] write_data;
    logic                      mismatch;
    logic [mts_pkg::DATA_W-1:0] error_count;
    logic                      done_res;
    logic                      failed;

    modport source (output valid, output access_kind, output to_scratch,
                    output word_offset, output write_data, output mismatch,
                    output error_count, output done_res, output failed,
                    input ready);
    modport sink   (input valid, input access_kind, input to_scratch,
                    input word_offset, input write_data, input mismatch,
                    input error_count, input done_res, input failed,
                    output ready);
endinterface

/* rtl/mts_cfg.sv */
`timescale 1ns / 1ps
// Configuration registers and clamped region size.
// Depends on mts_pkg.
module mts_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [mts_pkg::WORDS_W-1:0]       eff_words,
    output logic [mts_pkg::ITER_W-1:0]        iter_limit
);
    import mts_pkg::*;

    logic [WORDS_W-1:0] region_words_reg;
    logic [ITER_W-1:0]  iter_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_words_reg <= REGION_WORDS_RST;
            iter_limit_reg   <= ITER_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REGION_WORDS: region_words_reg <= cfg_data[WORDS_W-1:0];
                REG_ITER_LIMIT:   iter_limit_reg   <= cfg_data[ITER_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (region_words_reg < MIN_WORDS)
            eff_words = MIN_WORDS;
        else if (region_words_reg > MAX_WORDS)
            eff_words = MAX_WORDS;
        else
            eff_words = region_words_reg;
    end

    assign iter_limit = iter_limit_reg;

endmodule

/* rtl/mts_step.sv */
`timescale 1ns / 1ps
// Next-state and access logic for one command word.
// Depends on mts_pkg.
module mts_step (
    input  mts_pkg::mts_state_t               state,
    input  logic                              cmd,
    input  logic [mts_pkg::DATA_W-1:0]        read_data,
    input  logic [mts_pkg::WORDS_W-1:0]       eff_words,
    input  logic [mts_pkg::ITER_W-1:0]        iter_limit,
    output mts_pkg::mts_state_t               state_next,
    output mts_pkg::mts_result_t              result
);
    import mts_pkg::*;

    mts_state_t         s1;
    logic [DATA_W-1:0]  v;
    logic [DATA_W-1:0]  walk_sh;
    logic [DATA_W-1:0]  inc_val;
    logic [WORDS_W-1:0] scan_sh;
    logic [WORDS_W-1:0] scan_inc;
    logic [WORDS_W-1:0] probe_sh;
    logic               rd;
    logic               skip;
    logic               is_inv;

    always_comb
    begin
        state_next = state;
        s1         = state;
        result     = '0;
        rd         = 1'b0;
        skip       = 1'b0;
        v          = '0;
        walk_sh    = '0;
        inc_val    = '0;
        scan_sh    = '0;
        scan_inc   = '0;
        probe_sh   = '0;
        is_inv     = 1'b0;

        if (!cmd)
        begin
            state_next = '0;
        end
        else
        begin
            if (state.read_pending)
            begin
                if (!state.skip_compare && read_data != state.expected_value)
                begin
                    result.mismatch = 1'b1;
                    if (state.errors != '1)
                        state_next.errors = state.errors + 1'b1;
                end
                state_next.read_pending = 1'b0;
            end

            if (state.phase == PH_IDLE)
            begin
                if (iter_limit != '0 && state.passes_done >= iter_limit)
                    state_next.phase = PH_DONE;
                else
                begin
                    state_next.passes_done = state.passes_done + 1'b1;
                    state_next.phase       = PH_DATA;
                    state_next.sub_step    = '0;
                    state_next.seed_index  = '0;
                    state_next.walk_value  = SEEDS[0];
                end
            end

            s1       = state_next;
            v        = s1.walk_value;
            walk_sh  = {v[DATA_W-2:0], 1'b0};
            scan_sh  = {s1.scan_offset, 1'b0};
            scan_inc = {1'b0, s1.scan_offset} + 1'b1;
            probe_sh = {s1.probe_offset, 1'b0};
            inc_val  = DATA_W'(scan_inc);
            is_inv   = (s1.phase == PH_IINV);

            case (s1.phase)
                PH_DATA:
                begin
                    case (s1.sub_step)
                        3'd0:
                        begin
                            result.access_kind = ACC_WRITE;
                            result.write_data  = v;
                        end
                        3'd1:
                        begin
                            result.access_kind = ACC_WRITE;
                            result.to_scratch  = 1'b1;
                            result.write_data  = ~v;
                        end
                        3'd2:
                        begin
                            result.access_kind        = ACC_READ;
                            rd                        = 1'b1;
                            state_next.expected_value = v;
                        end
                        3'd3:
                        begin
                            result.access_kind = ACC_WRITE;
                            result.write_data  = ~v;
                        end
                        3'd4:
                        begin
                            result.access_kind = ACC_WRITE;
                            result.to_scratch  = 1'b1;
                            result.write_data  = v;
                        end
                        default:
                        begin
                            result.access_kind        = ACC_READ;
                            rd                        = 1'b1;
                            state_next.expected_value = ~v;
                        end
                    endcase
                    if (s1.sub_step < 3'd5)
                        state_next.sub_step = s1.sub_step + 1'b1;
                    else
                    begin
                        state_next.sub_step   = '0;
                        state_next.walk_value = walk_sh;
                        if (walk_sh == '0)
                        begin
                            if (s1.seed_index == 3'd7)
                            begin
                                state_next.phase       = PH_AFILL;
                                state_next.scan_offset = ADDR_W'(1);
                            end
                            else
                            begin
                                state_next.seed_index = s1.seed_index + 1'b1;
                                state_next.walk_value = SEEDS[s1.seed_index + 1'b1];
                            end
                        end
                    end
                end
                PH_AFILL:
                begin
                    result.access_kind     = ACC_WRITE;
                    result.word_offset     = s1.scan_offset;
                    result.write_data      = PAT_A;
                    state_next.scan_offset = scan_sh[ADDR_W-1:0];
                    if (scan_sh >= eff_words)
                        state_next.phase = PH_AHIGH0;
                end
                PH_AHIGH0:
                begin
                    result.access_kind     = ACC_WRITE;
                    result.write_data      = PAT_5;
                    state_next.phase       = PH_AHIGHCHK;
                    state_next.scan_offset = ADDR_W'(1);
                end
                PH_AHIGHCHK:
                begin
                    result.access_kind        = ACC_READ;
                    rd                        = 1'b1;
                    result.word_offset        = s1.scan_offset;
                    state_next.expected_value = PAT_A;
                    state_next.scan_offset    = scan_sh[ADDR_W-1:0];
                    if (scan_sh >= eff_words)
                        state_next.phase = PH_AHIGHEND;
                end
                PH_AHIGHEND:
                begin
                    result.access_kind      = ACC_WRITE;
                    result.write_data       = PAT_A;
                    state_next.phase        = PH_ALOW;
                    state_next.sub_step     = '0;
                    state_next.probe_offset = ADDR_W'(1);
                end
                PH_ALOW:
                begin
                    if (s1.sub_step == 3'd0)
                    begin
                        result.access_kind     = ACC_WRITE;
                        result.word_offset     = s1.probe_offset;
                        result.write_data      = PAT_5;
                        state_next.sub_step    = 3'd1;
                        state_next.scan_offset = ADDR_W'(1);
                    end
                    else if (s1.sub_step == 3'd1)
                    begin
                        result.access_kind        = ACC_READ;
                        rd                        = 1'b1;
                        result.word_offset        = s1.scan_offset;
                        state_next.expected_value = PAT_A;
                        skip                      = (s1.scan_offset == s1.probe_offset);
                        state_next.scan_offset    = scan_sh[ADDR_W-1:0];
                        if (scan_sh >= eff_words)
                            state_next.sub_step = 3'd2;
                    end
                    else
                    begin
                        result.access_kind      = ACC_WRITE;
                        result.word_offset      = s1.probe_offset;
                        result.write_data       = PAT_A;
                        state_next.sub_step     = '0;
                        state_next.probe_offset = probe_sh[ADDR_W-1:0];
                        if (probe_sh >= eff_words)
                        begin
                            state_next.phase       = PH_IFILL;
                            state_next.scan_offset = '0;
                        end
                    end
                end
                PH_IFILL:
                begin
                    result.access_kind     = ACC_WRITE;
                    result.word_offset     = s1.scan_offset;
                    result.write_data      = inc_val;
                    state_next.scan_offset = scan_inc[ADDR_W-1:0];
                    if (scan_inc >= eff_words)
                    begin
                        state_next.phase       = PH_IINV;
                        state_next.scan_offset = '0;
                        state_next.sub_step    = '0;
                    end
                end
                PH_IINV, PH_IZERO:
                begin
                    result.word_offset = s1.scan_offset;
                    if (s1.sub_step == 3'd0)
                    begin
                        result.access_kind        = ACC_READ;
                        rd                        = 1'b1;
                        state_next.expected_value = is_inv ? inc_val : ~inc_val;
                        state_next.sub_step       = 3'd1;
                    end
                    else
                    begin
                        result.access_kind     = ACC_WRITE;
                        result.write_data      = is_inv ? ~inc_val : '0;
                        state_next.sub_step    = '0;
                        state_next.scan_offset = scan_inc[ADDR_W-1:0];
                        if (scan_inc >= eff_words)
                        begin
                            state_next.scan_offset = '0;
                            state_next.phase       = is_inv ? PH_IZERO : PH_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (rd)
            begin
                state_next.read_pending = 1'b1;
                state_next.skip_compare = skip;
            end
        end

        result.error_count = state_next.errors;
        result.done_res    = (state_next.phase == PH_DONE);
        result.failed      = (state_next.phase == PH_DONE) && (state_next.errors != '0);
    end

endmodule

/* rtl/memory_test_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the memory test sequencer: state and output registers.
// Depends on mts_pkg, mts_if, mts_cfg and mts_step.
//
//   Channel  Dir  Handshake        Word
//   in_ch    in   valid/ready      cmd, read_data
//   out_ch   out  valid/ready      access_kind .. failed
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// One command word per cycle unless out_ch stalls; access word in the cycle after acceptance.
// The whole step for a word is one combinational pass between state and output registers.
// A full output register holds while out_ch stalls; in_ch stays ready when out_ch takes the word.
// Reset restores the configuration defaults and the idle pass start; no clearing pass.
module memory_test_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    mts_in_if.sink                            in_ch,
    mts_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [mts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mts_pkg::*;

    mts_state_t         state_reg;
    mts_state_t         state_next;
    mts_result_t        result_reg;
    mts_result_t        result_next;
    logic               out_valid_reg;
    logic               accept;
    logic [WORDS_W-1:0] eff_words;
    logic [ITER_W-1:0]  iter_limit;

    mts_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .eff_words  (eff_words),
        .iter_limit (iter_limit)
    );

    mts_step u_step (
        .state      (state_reg),
        .cmd        (in_ch.cmd),
        .read_data  (in_ch.read_data),
        .eff_words  (eff_words),
        .iter_limit (iter_limit),
        .state_next (state_next),
        .result     (result_next)
    );

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.access_kind = result_reg.access_kind;
    assign out_ch.to_scratch  = result_reg.to_scratch;
    assign out_ch.word_offset = result_reg.word_offset;
    assign out_ch.write_data  = result_reg.write_data;
    assign out_ch.mismatch    = result_reg.mismatch;
    assign out_ch.error_count = result_reg.error_count;
    assign out_ch.done_res    = result_reg.done_res;
    assign out_ch.failed      = result_reg.failed;

endmodule

/* rtl/mts_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the access words of the sequencer, bound to the top level.
// Depends on mts_pkg and memory_test_sequencer.
module mts_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [1:0]                   access_kind,
    input  logic                         to_scratch,
    input  logic [mts_pkg::ADDR_W-1:0]   word_offset,
    input  logic                         mismatch,
    input  logic [mts_pkg::DATA_W-1:0]   error_count,
    input  logic                         done_res,
    input  logic                         failed
);
    import mts_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> access_kind == ACC_NONE)
        else $error("access issued after test done");

    a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && failed |-> done_res && error_count != '0)
        else $error("failed without done or errors");

    a_mis_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mismatch |-> error_count != '0)
        else $error("mismatch not counted");

    a_scratch_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && to_scratch |-> word_offset == '0 && access_kind != ACC_NONE)
        else $error("scratch access with region offset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(error_count)
                                    && $stable(access_kind))
        else $error("stalled word changed");

endmodule

bind memory_test_sequencer mts_checker u_mts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .access_kind (out_ch.access_kind),
    .to_scratch  (out_ch.to_scratch),
    .word_offset (out_ch.word_offset),
    .mismatch    (out_ch.mismatch),
    .error_count (out_ch.error_count),
    .done_res    (out_ch.done_res),
    .failed      (out_ch.failed)
);
